>>> rtl/core/tcw_pkg.sv
// Text console character writer: shared types and constants.
// Request, configuration and cell layouts, command and register codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    localparam int CHAR_W = 8;
    localparam int NIB_W  = 4;
    localparam int ADDR_W = 11;
    localparam int ATTR_W = 8;
    localparam int TABW_W = 4;
    localparam int CNT_W  = 4;

    typedef enum logic [1:0] {
        CMD_PUT    = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    localparam logic REG_BLANK_ATTR = 1'b0;
    localparam logic REG_TAB_WIDTH  = 1'b1;

    localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_RETURN  = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_BLANK   = 8'h00;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
    localparam logic [TABW_W-1:0] RESET_TAB  = 4'd4;

    typedef struct packed {
        t_cmd              command;
        logic [CHAR_W-1:0] char_code;
        logic [NIB_W-1:0]  foreground;
        logic [NIB_W-1:0]  background;
        logic [ADDR_W-1:0] cell_address;
    } t_req;

    typedef struct packed {
        logic [ATTR_W-1:0] blank_attr;
        logic [TABW_W-1:0] tab_width;
    } t_cfg;

    typedef struct packed {
        logic [ATTR_W-1:0] attr;
        logic [CHAR_W-1:0] chr;
    } t_cell;

endpackage

`default_nettype wire

>>> rtl/core/tcw_engine.sv
// Text console engine: cell store, cursor registers and command sequencer.
// Puts/deletes use the cursor address, reads the request's, sweeps a pointer.
// Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_engine
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire t_req                        i_req,
    input  wire t_cfg                        i_cfg,
    output logic                             o_busy,
    output logic                             o_done,
    output logic [$clog2(ROWS)-1:0]          o_row,
    output logic [$clog2(COLUMNS)-1:0]       o_col,
    output t_cell                            o_rd
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int RMW   = (CW > TABW_W) ? CW : TABW_W;

    typedef enum logic [10:0] {
        S_INIT     = 11'b000_0000_0001,
        S_IDLE     = 11'b000_0000_0010,
        S_EXEC     = 11'b000_0000_0100,
        S_TABDIV   = 11'b000_0000_1000,
        S_PUT      = 11'b000_0001_0000,
        S_SCROLL   = 11'b000_0010_0000,
        S_SCRBLANK = 11'b000_0100_0000,
        S_CLEAR    = 11'b000_1000_0000,
        S_BLANK    = 11'b001_0000_0000,
        S_RDWAIT   = 11'b010_0000_0000,
        S_DONE     = 11'b100_0000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_ptr, n_ptr;
    logic [RW-1:0]     r_row, n_row;
    logic [CW-1:0]     r_col, n_col;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [RMW-1:0]    r_rem, n_rem;
    t_req              r_req, n_req;
    t_cell             r_put, n_put;
    t_cell             r_rd, n_rd;

    t_cell             r_mem [CELLS];
    t_cell             r_rdata;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     mem_raddr;
    t_cell             mem_wdata;

    logic [AW-1:0]     cur_addr;
    logic [RMW-1:0]    tw_eff;
    logic              last_col;
    logic              last_row;
    logic              last_ptr;
    logic              move_end;
    logic              rd_in_range;
    t_cell             blank;

    assign cur_addr    = AW'(r_row * COLUMNS + r_col);
    assign tw_eff      = RMW'((i_cfg.tab_width == '0) ? TABW_W'(1) : i_cfg.tab_width);
    assign last_col    = (r_col == CW'(COLUMNS - 1));
    assign last_row    = (r_row == RW'(ROWS - 1));
    assign last_ptr    = (r_ptr == AW'(CELLS - 1));
    assign move_end    = (r_ptr == AW'(CELLS - COLUMNS));
    assign rd_in_range = (32'(r_req.cell_address) < CELLS);
    assign blank       = '{attr: i_cfg.blank_attr, chr: CHAR_BLANK};

    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_row     = r_row;
        n_col     = r_col;
        n_cnt     = r_cnt;
        n_rem     = r_rem;
        n_req     = r_req;
        n_put     = r_put;
        n_rd      = r_rd;
        mem_we    = 1'b0;
        mem_waddr = cur_addr;
        mem_wdata = blank;
        mem_raddr = AW'(r_req.cell_address);

        unique case (r_state)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr;
                mem_wdata = '{attr: RESET_ATTR, chr: CHAR_BLANK};
                if (last_ptr) begin
                    n_ptr   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_req   = i_req;
                    n_rd    = '0;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_req.command)
                    CMD_PUT: begin
                        n_put = '{attr: {r_req.background, r_req.foreground},
                                  chr: r_req.char_code};
                        n_cnt = CNT_W'(1);
                        if (r_req.char_code == CHAR_NEWLINE) begin
                            n_col = '0;
                            n_cnt = '0;
                            if (last_row) begin
                                n_ptr   = '0;
                                n_state = S_SCROLL;
                            end else begin
                                n_row   = r_row + RW'(1);
                                n_state = S_DONE;
                            end
                        end else if (r_req.char_code == CHAR_RETURN) begin
                            n_col   = '0;
                            n_state = S_DONE;
                        end else if (r_req.char_code == CHAR_TAB) begin
                            n_put.chr = CHAR_SPACE;
                            n_rem     = RMW'(r_col);
                            n_state   = S_TABDIV;
                        end else begin
                            n_state = S_PUT;
                        end
                    end
                    CMD_DELETE: begin
                        if (r_col == '0) begin
                            if (r_row != '0) begin
                                n_row = r_row - RW'(1);
                            end
                            n_col = CW'(COLUMNS - 1);
                        end else begin
                            n_col = r_col - CW'(1);
                        end
                        n_state = S_BLANK;
                    end
                    CMD_CLEAR: begin
                        n_ptr   = '0;
                        n_row   = '0;
                        n_col   = '0;
                        n_state = S_CLEAR;
                    end
                    CMD_READ: begin
                        n_state = rd_in_range ? S_RDWAIT : S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_TABDIV: begin
                // reduce column modulo tab width, one subtract per cycle
                if (r_rem >= tw_eff) begin
                    n_rem = r_rem - tw_eff;
                end else begin
                    n_cnt   = CNT_W'(tw_eff - r_rem);
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = cur_addr;
                mem_wdata = r_put;
                n_cnt     = r_cnt - CNT_W'(1);
                if (last_col) begin
                    n_col = '0;
                    if (last_row) begin
                        n_ptr   = '0;
                        n_state = S_SCROLL;
                    end else begin
                        n_row   = r_row + RW'(1);
                        n_state = (r_cnt == CNT_W'(1)) ? S_DONE : S_PUT;
                    end
                end else begin
                    n_col   = r_col + CW'(1);
                    n_state = (r_cnt == CNT_W'(1)) ? S_DONE : S_PUT;
                end
            end
            S_SCROLL: begin
                // read one row ahead, write the previous cycle's read one slot back
                mem_raddr = AW'(r_ptr + COLUMNS);
                mem_we    = (r_ptr != '0);
                mem_waddr = r_ptr - AW'(1);
                mem_wdata = r_rdata;
                if (move_end) begin
                    n_state = S_SCRBLANK;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            S_SCRBLANK: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr;
                if (last_ptr) begin
                    n_ptr   = '0;
                    n_state = (r_cnt == '0) ? S_DONE : S_PUT;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr;
                if (last_ptr) begin
                    n_ptr   = '0;
                    n_state = S_DONE;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            S_BLANK: begin
                mem_we    = 1'b1;
                mem_waddr = cur_addr;
                n_state   = S_DONE;
            end
            S_RDWAIT: begin
                n_rd    = r_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ptr   <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_cnt   <= '0;
            r_rd    <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_row   <= n_row;
            r_col   <= n_col;
            r_cnt   <= n_cnt;
            r_rd    <= n_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_put <= n_put;
        r_rem <= n_rem;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);
    assign o_row  = r_row;
    assign o_col  = r_col;
    assign o_rd   = r_rd;

endmodule

`default_nettype wire

>>> rtl/core/text_console_character_writer.sv
// Text console character writer: top level with configuration registers
// and the registered result port. Depends on tcw_pkg and tcw_engine.
//
// Usage: raise start with a command on the request ports; the request is
// taken at a clock edge where start is high and busy is low. Exactly one
// result follows, shown for one cycle with o_done high, carrying the linear
// cursor position and, for a read inside the store, the addressed cell
// (zero otherwise). A tab reduces the column modulo the tab width and then
// puts spaces up to the next tab stop; a put that moves past the last row
// adds a scroll sweep over the store, and clear sweeps the whole store.
// The sequencer writes the cell store one cell per cycle. A new request may
// be taken in the cycle that shows o_done. The receiver cannot stall:
// results are not held. Reset: the sequencer sweeps the whole store to
// character 0, attribute 7, with busy high; configuration writes on
// i_cfg_we / i_cfg_addr / i_cfg_wdata are taken at any time, with no wait.
`timescale 1ns / 1ps
`default_nettype none

module text_console_character_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        i_command,
    input  wire logic [CHAR_W-1:0] i_char_code,
    input  wire logic [NIB_W-1:0]  i_foreground,
    input  wire logic [NIB_W-1:0]  i_background,
    input  wire logic [ADDR_W-1:0] i_cell_address,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_addr,
    input  wire logic [ATTR_W-1:0] i_cfg_wdata,
    output logic                   o_done,
    output logic [ADDR_W-1:0]      o_cursor_pos,
    output logic [CHAR_W-1:0]      o_cell_char,
    output logic [ATTR_W-1:0]      o_cell_attr
);

    t_cfg                         r_cfg;
    t_req                         req;
    t_cell                        eng_rd;
    logic                         eng_busy;
    logic                         eng_done;
    logic [$clog2(ROWS)-1:0]      eng_row;
    logic [$clog2(COLUMNS)-1:0]   eng_col;

    logic                         r_done;
    logic [ADDR_W-1:0]            r_pos;
    t_cell                        r_cell;

    assign req = '{command:      t_cmd'(i_command),
                   char_code:    i_char_code,
                   foreground:   i_foreground,
                   background:   i_background,
                   cell_address: i_cell_address};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.blank_attr <= RESET_ATTR;
            r_cfg.tab_width  <= RESET_TAB;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_BLANK_ATTR: r_cfg.blank_attr <= i_cfg_wdata;
                REG_TAB_WIDTH:  r_cfg.tab_width  <= i_cfg_wdata[TABW_W-1:0];
                default: ;
            endcase
        end
    end

    tcw_engine #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (req),
        .i_cfg   (r_cfg),
        .o_busy  (eng_busy),
        .o_done  (eng_done),
        .o_row   (eng_row),
        .o_col   (eng_col),
        .o_rd    (eng_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= eng_done;
        end
    end

    // result payload, linearized cursor masked to the port width
    always_ff @(posedge i_clk) begin
        r_pos  <= ADDR_W'(eng_row * COLUMNS + eng_col);
        r_cell <= eng_rd;
    end

    assign busy         = eng_busy;
    assign o_done       = r_done;
    assign o_cursor_pos = r_pos;
    assign o_cell_char  = r_cell.chr;
    assign o_cell_attr  = r_cell.attr;

endmodule

`default_nettype wire

>>> rtl/core/tcw_checker.sv
// Port-level checks for the text console character writer, and the bind
// that attaches them to the top level. Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_checker
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              o_done,
    input wire logic [ADDR_W-1:0] o_cursor_pos
);

    a_init_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("not busy after reset");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while still busy");

    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without preceding work");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (32'(o_cursor_pos) < ROWS * COLUMNS))
        else $error("cursor position outside the screen");

endmodule

bind text_console_character_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_cursor_pos (o_cursor_pos)
);

`default_nettype wire
